// File: rtl/dbfd_pkg.sv
// shared types, constants and codes for the detection box frame dedup block
package dbfd_pkg;

    // coordinate and field widths
    localparam int COORD_BITS    = 12;
    localparam int AREA_W        = 2 * COORD_BITS;
    localparam int CONF_W        = 9;
    localparam int PAD_W         = 8;
    localparam int TOTAL_W       = 32;
    localparam int GROUP_W       = 21;
    localparam int GROUP_SIZE    = 3000;
    localparam int REM_W         = $clog2(GROUP_SIZE);
    localparam int MAX_BOXES_DEF = 32;

    // stream and config port widths
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 104;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;

    // register reset values
    localparam logic [CONF_W-1:0]     CONF_RESET  = CONF_W'(64);
    localparam logic [PAD_W-1:0]      PAD_RESET   = PAD_W'(10);
    localparam logic [COORD_BITS-1:0] WIDTH_RESET = COORD_BITS'(1920);
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_THRESHOLD,
        CFG_BOX_PAD,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_AREA,
        ST_AWAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } box_t;

    // stored box with its precomputed area
    typedef struct packed {
        logic [AREA_W-1:0] area;
        box_t              box;
    } entry_t;

    // requests into the shared match unit
    typedef struct packed {
        logic area_req;
        logic cmp_req;
    } mu_req_t;

    // status back from the shared match unit
    typedef struct packed {
        logic busy;
        logic area_valid;
        logic match_valid;
        logic match;
    } mu_stat_t;

endpackage

// File: rtl/detection_box_frame_dedup.sv
// top level: detection filter, pad and clamp, iou dedup against the previous frame
// Each accepted detection whose confidence reaches conf_threshold is padded by
// box_pad and clamped to the image, then compared by intersection over union
// (match when 5*inter > 3*union) with every box kept from the previous frame.
// The box list lives in one memory split into two halves that swap roles at
// frame end, so the swap itself is only a flip of the bank select. When the
// previous frame kept at least one box, a kept detection goes through pad,
// area, the multiplier latency, one memory read per stored box, a drain of
// the read and compare pipeline, and the result write before s_tready
// returns. With an empty previous list the scan and drain are skipped. All
// multiplies go through one shared multiplier inside the match unit, which
// is what sets the one stored box per cycle pace. An item that is dropped or
// carries only frame end is taken without leaving the idle state. A result
// waits in the output register, and the block keeps accepting while it waits;
// only the final step of the next kept box stalls on an unread result. The
// running count of new boxes wraps at 32 bits and its group number (count /
// 3000) is kept by a side counter, so no divider is needed. Configuration
// writes are always ready and should be made only while the block is idle.
module detection_box_frame_dedup #(
    parameter int MAX_BOXES = dbfd_pkg::MAX_BOXES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // confidence, left_edge, top_edge, right_edge, bottom_edge, zero fill
    input  logic [dbfd_pkg::IN_DATA_W-1:0]  s_tdata,
    // has_box
    input  logic                            s_tuser,
    // frame_end
    input  logic                            s_tlast,
    // result out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // box_x, box_y, box_width, box_height, image_number, group_number, zero fill
    output logic [dbfd_pkg::OUT_DATA_W-1:0] m_tdata,
    // is_new
    output logic                            m_tuser,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbfd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dbfd_pkg::*;

    localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int SW     = COORD_BITS + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(GROUP_SIZE - 1);

    // clamp a signed extent into the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic [COORD_BITS-1:0] r;
        begin
            if (v[SW-1])
            begin
                r = '0;
            end
            else if (v[SW-2])
            begin
                r = '1;
            end
            else
            begin
                r = v[COORD_BITS-1:0];
            end
            return r;
        end
    endfunction

    // configuration registers
    logic [CONF_W-1:0]     thr_reg;
    logic [PAD_W-1:0]      pad_reg;
    logic [COORD_BITS-1:0] img_w_reg, img_h_reg;

    // sequencer
    state_t                state_reg, state_next;
    logic                  s_tready_c, area_req_c, rd_issue_c, done_fire_c;

    // latched request
    logic [COORD_BITS-1:0] l_reg, t_reg, r_reg, b_reg;
    logic                  fe_reg;

    // working box and scan state
    box_t                  nb_reg;
    box_t                  nb_pad;
    logic [AREA_W-1:0]     area_a_reg;
    logic                  matched_reg;
    logic [CNT_W-1:0]      scan_idx_reg;
    logic                  rd_valid_reg;
    logic                  scan_last;

    // list bookkeeping, bank_reg is the half holding the current frame
    logic [CNT_W-1:0]      prev_count_reg, cur_count_reg, cur_store;
    logic                  bank_reg;

    // running totals
    logic [TOTAL_W-1:0]    total_reg, total_n;
    logic [GROUP_W-1:0]    group_reg, group_n;
    logic [REM_W-1:0]      rem_reg, rem_n;
    logic                  is_new;

    // result register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_user_reg;

    // request field views
    logic [CONF_W-1:0]     in_conf;
    logic                  in_kept;

    // padding math
    logic [COORD_BITS:0]   r_plus, b_plus;
    logic signed [SW-1:0]  w_raw, h_raw;
    logic [COORD_BITS-1:0] pad_ext;

    // memory and match unit hookup
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    entry_t                wr_entry, rd_entry;
    mu_req_t               mu_req;
    mu_stat_t              mu_stat;
    logic [AREA_W-1:0]     mu_product;

    assign in_conf = s_tdata[CONF_W-1:0];
    assign in_kept = s_tuser & (in_conf >= thr_reg);

    // sequencer next state and strobes
    always_comb
    begin
        state_next  = state_reg;
        s_tready_c  = 1'b0;
        area_req_c  = 1'b0;
        rd_issue_c  = 1'b0;
        done_fire_c = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready_c = 1'b1;
                if (s_tvalid && in_kept)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                state_next = ST_AREA;
            end
            ST_AREA:
            begin
                area_req_c = 1'b1;
                state_next = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                if (mu_stat.area_valid)
                begin
                    state_next = (prev_count_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_issue_c = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mu_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    done_fire_c = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_last = (scan_idx_reg + CNT_W'(1)) == prev_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // pad left and top, clamp right and bottom to the image
    always_comb
    begin
        pad_ext  = {{(COORD_BITS-PAD_W){1'b0}}, pad_reg};
        nb_pad.x = (l_reg < pad_ext) ? '0 : l_reg - pad_ext;
        nb_pad.y = (t_reg < pad_ext) ? '0 : t_reg - pad_ext;
        r_plus   = {1'b0, r_reg} + {1'b0, pad_ext};
        b_plus   = {1'b0, b_reg} + {1'b0, pad_ext};
        if (r_plus < {1'b0, img_w_reg})
        begin
            w_raw = $signed({1'b0, r_plus}) - $signed({2'b00, l_reg});
        end
        else
        begin
            w_raw = $signed({2'b00, img_w_reg}) - $signed({2'b00, l_reg});
        end
        if (b_plus < {1'b0, img_h_reg})
        begin
            h_raw = $signed({1'b0, b_plus}) - $signed({2'b00, t_reg});
        end
        else
        begin
            h_raw = $signed({2'b00, img_h_reg}) - $signed({2'b00, t_reg});
        end
        nb_pad.w = sat_coord(w_raw);
        nb_pad.h = sat_coord(h_raw);
    end

    // running count and its group, wrap of the count restarts both
    always_comb
    begin
        is_new  = ~matched_reg;
        total_n = total_reg;
        group_n = group_reg;
        rem_n   = rem_reg;
        if (is_new)
        begin
            total_n = total_reg + TOTAL_W'(1);
            if (total_reg == '1)
            begin
                group_n = '0;
                rem_n   = '0;
            end
            else if (rem_reg == REM_LAST)
            begin
                group_n = group_reg + GROUP_W'(1);
                rem_n   = '0;
            end
            else
            begin
                rem_n = rem_reg + REM_W'(1);
            end
        end
    end

    // store the box only while the current list has room
    assign wr_en     = done_fire_c && (cur_count_reg < CNT_MAX);
    assign cur_store = wr_en ? cur_count_reg + CNT_W'(1) : cur_count_reg;
    assign wr_addr   = {bank_reg, cur_count_reg[IDX_W-1:0]};
    assign rd_addr   = {~bank_reg, scan_idx_reg[IDX_W-1:0]};
    assign wr_entry  = '{area: area_a_reg, box: nb_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= CONF_RESET;
            pad_reg        <= PAD_RESET;
            img_w_reg      <= WIDTH_RESET;
            img_h_reg      <= HEIGHT_RESET;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            bank_reg       <= 1'b0;
            total_reg      <= '0;
            group_reg      <= '0;
            rem_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CONF_THRESHOLD: thr_reg   <= cfg_data[CONF_W-1:0];
                    CFG_BOX_PAD:        pad_reg   <= cfg_data[PAD_W-1:0];
                    CFG_IMAGE_WIDTH:    img_w_reg <= cfg_data[COORD_BITS-1:0];
                    CFG_IMAGE_HEIGHT:   img_h_reg <= cfg_data[COORD_BITS-1:0];
                    default:            thr_reg   <= thr_reg;
                endcase
            end

            rd_valid_reg <= rd_issue_c;

            // dropped or bare frame-end request swaps the lists right away
            if (s_tvalid && s_tready_c && !in_kept && s_tlast)
            begin
                bank_reg       <= ~bank_reg;
                prev_count_reg <= cur_count_reg;
                cur_count_reg  <= '0;
            end

            if (done_fire_c)
            begin
                total_reg <= total_n;
                group_reg <= group_n;
                rem_reg   <= rem_n;
                if (fe_reg)
                begin
                    bank_reg       <= ~bank_reg;
                    prev_count_reg <= cur_store;
                    cur_count_reg  <= '0;
                end
                else
                begin
                    cur_count_reg <= cur_store;
                end
            end

            if (done_fire_c)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready_c)
        begin
            l_reg  <= s_tdata[CONF_W +: COORD_BITS];
            t_reg  <= s_tdata[CONF_W + COORD_BITS +: COORD_BITS];
            r_reg  <= s_tdata[CONF_W + 2*COORD_BITS +: COORD_BITS];
            b_reg  <= s_tdata[CONF_W + 3*COORD_BITS +: COORD_BITS];
            fe_reg <= s_tlast;
        end
        if (state_reg == ST_PAD)
        begin
            nb_reg <= nb_pad;
        end
        if (mu_stat.area_valid)
        begin
            area_a_reg <= mu_product;
        end
        if (state_reg == ST_PAD)
        begin
            matched_reg <= 1'b0;
        end
        else if (mu_stat.match_valid && mu_stat.match)
        begin
            matched_reg <= 1'b1;
        end
        if (state_reg == ST_AWAIT)
        begin
            scan_idx_reg <= '0;
        end
        else if (rd_issue_c)
        begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        if (done_fire_c)
        begin
            m_data_reg <= OUT_DATA_W'({group_n, total_n,
                                       nb_reg.h, nb_reg.w, nb_reg.y, nb_reg.x});
            m_user_reg <= is_new;
        end
    end

    assign mu_req = '{area_req: area_req_c, cmp_req: rd_valid_reg};

    dbfd_box_ram #(
        .ADDR_W (ADDR_W)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_issue_c),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    dbfd_match_unit u_match_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mu_req),
        .box_a   (nb_reg),
        .area_a  (area_a_reg),
        .entry_b (rd_entry),
        .product (mu_product),
        .stat    (mu_stat)
    );

    assign s_tready  = s_tready_c;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: rtl/dbfd_box_ram.sv
// box list memory, one write port and one registered read port
module dbfd_box_ram #(
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  dbfd_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output dbfd_pkg::entry_t     rd_data
);
    import dbfd_pkg::*;

    entry_t mem [2**ADDR_W];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dbfd_match_unit.sv
// shared overlap, multiply and iou compare pipeline
module dbfd_match_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dbfd_pkg::mu_req_t             req,
    input  dbfd_pkg::box_t                box_a,
    input  logic [dbfd_pkg::AREA_W-1:0]   area_a,
    input  dbfd_pkg::entry_t              entry_b,
    output logic [dbfd_pkg::AREA_W-1:0]   product,
    output dbfd_pkg::mu_stat_t            stat
);
    import dbfd_pkg::*;

    localparam int EW = COORD_BITS + 1;

    logic [EW-1:0]         a_xe, a_ye, b_xe, b_ye;
    logic [COORD_BITS-1:0] x0, y0;
    logic [EW-1:0]         x1, y1;
    logic [EW-1:0]         ow_diff, oh_diff;
    logic                  ok_x, ok_y;

    logic                  s1_valid_reg, s2_valid_reg;
    logic                  s1_area_reg, s2_area_reg;
    logic                  s1_ok_reg, s2_ok_reg;
    logic [COORD_BITS-1:0] s1_op_a_reg, s1_op_b_reg;
    logic [AREA_W-1:0]     s1_area_b_reg, s2_area_b_reg;
    logic [AREA_W-1:0]     prod_reg;

    logic [AREA_W:0]       area_sum;
    logic [AREA_W+2:0]     union_x3;
    logic [AREA_W+2:0]     inter_x8;

    // overlap along each axis, empty when the far edge does not pass the near one
    always_comb
    begin
        a_xe    = {1'b0, box_a.x} + {1'b0, box_a.w};
        a_ye    = {1'b0, box_a.y} + {1'b0, box_a.h};
        b_xe    = {1'b0, entry_b.box.x} + {1'b0, entry_b.box.w};
        b_ye    = {1'b0, entry_b.box.y} + {1'b0, entry_b.box.h};
        x0      = (box_a.x > entry_b.box.x) ? box_a.x : entry_b.box.x;
        y0      = (box_a.y > entry_b.box.y) ? box_a.y : entry_b.box.y;
        x1      = (a_xe < b_xe) ? a_xe : b_xe;
        y1      = (a_ye < b_ye) ? a_ye : b_ye;
        ok_x    = {1'b0, x0} < x1;
        ok_y    = {1'b0, y0} < y1;
        ow_diff = x1 - {1'b0, x0};
        oh_diff = y1 - {1'b0, y0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.area_req | req.cmp_req;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_area_reg   <= req.area_req;
        s1_ok_reg     <= req.area_req | (ok_x & ok_y);
        s1_op_a_reg   <= req.area_req ? box_a.w : ow_diff[COORD_BITS-1:0];
        s1_op_b_reg   <= req.area_req ? box_a.h : oh_diff[COORD_BITS-1:0];
        s1_area_b_reg <= entry_b.area;
        prod_reg      <= s1_op_a_reg * s1_op_b_reg;
        s2_area_reg   <= s1_area_reg;
        s2_ok_reg     <= s1_ok_reg;
        s2_area_b_reg <= s1_area_b_reg;
    end

    // 5*inter > 3*(a + b - inter) rewritten as 8*inter > 3*(a + b)
    always_comb
    begin
        area_sum = {1'b0, area_a} + {1'b0, s2_area_b_reg};
        union_x3 = {2'b00, area_sum} + {1'b0, area_sum, 1'b0};
        inter_x8 = {prod_reg, 3'b000};
    end

    assign product          = prod_reg;
    assign stat.busy        = s1_valid_reg | s2_valid_reg;
    assign stat.area_valid  = s2_valid_reg & s2_area_reg;
    assign stat.match_valid = s2_valid_reg & ~s2_area_reg;
    assign stat.match       = s2_ok_reg & (inter_x8 > union_x3);

endmodule

// File: rtl/dbfd_checker.sv
// port-level checks on the dedup block, bound to the top level
module dbfd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dbfd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // a pending result is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // a pending result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // a new result only follows a busy cycle of the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without processing");

    // a request with no box does not stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("bare request stalled the input");

endmodule

bind detection_box_frame_dedup dbfd_checker u_dbfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
